### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Sequencer states and the character codes the writer treats specially.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_COPY  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  // Input function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Control characters and blank cell
  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  BLANK_ATTR = 8'h0F;
  localparam logic [15:0] BLANK_CELL = {BLANK_ATTR, CH_SPACE};

endpackage

### rtl/text_console_char_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_unit: character-cell text screen writer
// Keeps a ROWS x COLUMNS screen of glyph/attribute cells and a linear cursor,
// puts characters at the cursor, scrolls the screen and reads back cells.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | flow control
//  --------+-----------------------------------------------+--------------------
//  input   | start, busy, in_func, in_char_code,           | taken when start
//          | in_cell_index                                 | and not busy
//  result  | out_valid, out_cell_value, out_cursor_pos,    | one-cycle strobe,
//          | out_scrolled                                  | cannot be held off
//  config  | cfg_valid, cfg_ready, cfg_data                | valid/ready
//
// A put without scroll returns its result the cycle after it is taken and the
// next put may follow right away; a read does a memory read, then returns the
// result. A put that scrolls walks the shared address counter over the whole
// screen, one cell a cycle. After reset the screen is cleared one cell a cycle
// with busy high; config writes are taken throughout. The result side cannot
// stall.
module text_console_char_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  // result transaction
  output logic        out_valid,
  output logic [15:0] out_cell_value,
  output logic [10:0] out_cursor_pos,
  output logic        out_scrolled,
  // configuration transaction
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW  = $clog2(CELL_COUNT);
  localparam int CW  = $clog2(CELL_COUNT + 1);
  localparam int SW  = $clog2(CELL_COUNT + COLUMNS);
  localparam int CLW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [CW-1:0]  CUR_CELLS = CW'(CELL_COUNT);
  localparam logic [CW-1:0]  CUR_COLS  = CW'(COLUMNS);
  localparam logic [CW-1:0]  CUR_LAST  = CW'(CELL_COUNT - COLUMNS);
  localparam logic [SW-1:0]  CNT_COLS  = SW'(COLUMNS);
  localparam logic [SW-1:0]  CNT_CELLS = SW'(CELL_COUNT);
  localparam logic [SW-1:0]  CNT_CLR_END = SW'(CELL_COUNT - 1);
  localparam logic [SW-1:0]  CNT_END   = SW'(CELL_COUNT + COLUMNS - 1);
  localparam logic [CLW-1:0] COL_LAST  = CLW'(COLUMNS - 1);

  tcw_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [CLW-1:0]  col_r, col_nxt;
  logic [7:0]      attr_r, attr_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            pend_r, pend_nxt;
  logic            pend_blank_r, pend_blank_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_cell_value_r, out_cell_value_nxt;
  logic [10:0]     out_cursor_pos_r, out_cursor_pos_nxt;
  logic            out_scrolled_r, out_scrolled_nxt;

  logic            accept;
  logic [31:0]     idx32;
  logic            idx_in_range;
  logic [CW-1:0]   cur_step;
  logic [31:0]     cur_step32;
  logic [31:0]     cursor32;
  logic [CW-1:0]   cur_after;
  logic [31:0]     cur_after32;
  logic [SW-1:0]   cnt_minus_cols;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  assign accept    = start && (state_r == tcw_pkg::ST_IDLE);
  assign busy      = (state_r != tcw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign idx32        = 32'(in_cell_index);
  assign idx_in_range = (idx32 < 32'(CELL_COUNT));
  assign cnt_minus_cols = cnt_r - CNT_COLS;
  assign cursor32     = 32'(cursor_r);

  // Cursor after the character, before any scroll
  always_comb begin
    if (in_char_code == tcw_pkg::CH_NEWLINE) begin
      cur_step = cursor_r + (CUR_COLS - CW'(col_r));
    end else if (in_char_code == tcw_pkg::CH_RETURN) begin
      cur_step = cursor_r - CW'(col_r);
    end else begin
      cur_step = cursor_r + CW'(1);
    end
  end

  assign cur_after   = (cur_step == CUR_CELLS) ? CUR_LAST : cur_step;
  assign cur_step32  = 32'(cur_after);
  assign cur_after32 = cur_step32;

  // Memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = pend_blank_r ? tcw_pkg::BLANK_CELL : ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cnt_r[AW-1:0];
    case (state_r)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = tcw_pkg::BLANK_CELL;
      end
      tcw_pkg::ST_IDLE: begin
        ram_we    = accept && (in_func == tcw_pkg::FUNC_PUT) &&
                    (in_char_code != tcw_pkg::CH_NEWLINE) &&
                    (in_char_code != tcw_pkg::CH_RETURN);
        ram_waddr = cursor_r[AW-1:0];
        ram_wdata = {attr_r, in_char_code};
        ram_re    = accept && (in_func == tcw_pkg::FUNC_READ) && idx_in_range;
        ram_raddr = idx32[AW-1:0];
      end
      tcw_pkg::ST_COPY: begin
        ram_we = pend_r;
        ram_re = (cnt_r < CNT_CELLS);
      end
      tcw_pkg::ST_DRAIN: begin
        ram_we = pend_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer and cursor
  always_comb begin
    state_nxt          = state_r;
    cnt_nxt            = cnt_r;
    cursor_nxt         = cursor_r;
    col_nxt            = col_r;
    attr_nxt           = (cfg_valid && cfg_ready) ? cfg_data : attr_r;
    rd_ok_nxt          = rd_ok_r;
    pend_nxt           = pend_r;
    pend_blank_nxt     = pend_blank_r;
    pend_addr_nxt      = pend_addr_r;
    out_valid_nxt      = 1'b0;
    out_cell_value_nxt = out_cell_value_r;
    out_cursor_pos_nxt = out_cursor_pos_r;
    out_scrolled_nxt   = out_scrolled_r;
    case (state_r)
      // Blank the screen after reset
      tcw_pkg::ST_CLEAR: begin
        cnt_nxt = cnt_r + SW'(1);
        if (cnt_r == CNT_CLR_END) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      // Take a transaction; puts finish here unless they scroll
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == tcw_pkg::FUNC_READ) begin
            rd_ok_nxt = idx_in_range;
            state_nxt = tcw_pkg::ST_READ;
          end else begin
            cursor_nxt = cur_after;
            if ((in_char_code == tcw_pkg::CH_NEWLINE) ||
                (in_char_code == tcw_pkg::CH_RETURN) || (col_r == COL_LAST)) begin
              col_nxt = '0;
            end else begin
              col_nxt = col_r + CLW'(1);
            end
            if (cur_step == CUR_CELLS) begin
              cnt_nxt   = CNT_COLS;
              pend_nxt  = 1'b0;
              state_nxt = tcw_pkg::ST_COPY;
            end else begin
              out_valid_nxt      = 1'b1;
              out_cell_value_nxt = '0;
              out_cursor_pos_nxt = cur_after32[10:0];
              out_scrolled_nxt   = 1'b0;
            end
          end
        end
      end
      // Return the cell read
      tcw_pkg::ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_cell_value_nxt = rd_ok_r ? ram_rdata : '0;
        out_cursor_pos_nxt = cursor32[10:0];
        out_scrolled_nxt   = 1'b0;
        state_nxt          = tcw_pkg::ST_IDLE;
      end
      // Move each cell up one row, then blank the bottom row
      tcw_pkg::ST_COPY: begin
        pend_nxt       = 1'b1;
        pend_addr_nxt  = cnt_minus_cols[AW-1:0];
        pend_blank_nxt = (cnt_r >= CNT_CELLS);
        cnt_nxt        = cnt_r + SW'(1);
        if (cnt_r == CNT_END) begin
          state_nxt = tcw_pkg::ST_DRAIN;
        end
      end
      // Finish the last write and report the scroll
      tcw_pkg::ST_DRAIN: begin
        pend_nxt           = 1'b0;
        out_valid_nxt      = 1'b1;
        out_cell_value_nxt = '0;
        out_cursor_pos_nxt = cursor32[10:0];
        out_scrolled_nxt   = 1'b1;
        state_nxt          = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      cnt_r       <= '0;
      cursor_r    <= '0;
      col_r       <= '0;
      attr_r      <= tcw_pkg::BLANK_ATTR;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_ok_r          <= rd_ok_nxt;
    pend_blank_r     <= pend_blank_nxt;
    pend_addr_r      <= pend_addr_nxt;
    out_cell_value_r <= out_cell_value_nxt;
    out_cursor_pos_r <= out_cursor_pos_nxt;
    out_scrolled_r   <= out_scrolled_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_value_r;
  assign out_cursor_pos = out_cursor_pos_r;
  assign out_scrolled   = out_scrolled_r;

  // Screen cell memory
  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
